/* src/ffba_pkg.sv */
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and codes for the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

    localparam int unsigned ADDR_W    = 32;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned STATUS_W  = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT = 1'd1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_REUSED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_APPENDED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ZERO_SIZE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FREED     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN   = 3'd5;

    // request modes
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // rounding to 16 bytes
    localparam logic [ADDR_W:0] ALIGN_ADD  = 33'd15;
    localparam logic [ADDR_W:0] ALIGN_MASK = ~33'd15;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] size;
        logic              free;
    } ffba_entry_t;

    localparam int unsigned ENTRY_W = $bits(ffba_entry_t);

endpackage

/* src/ffba_ram.sv */
// ----------------------------------------------------------------------------
// ffba_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module ffba_ram #(
    parameter int unsigned WIDTH = 65,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/first_fit_block_allocator.sv */
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit heap block table: allocate (reuse or append) and free requests.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: in_valid / in_stall with mode, request_size, free_address.
//   A beat is taken when in_valid is high and in_stall is low. in_stall is high
//   from the accepted beat until the result is loaded into the output register.
//   Result channel: out_valid / out_stall with address and status, one result
//   beat per request, held in an output register while out_stall is high.
//   A zero-size allocate goes straight to the push step. Other requests
//   read the block table one entry per cycle through the RAM read port;
//   the scan stops at the first matching entry or at the entry count, and
//   an allocate that misses goes on to the append step. The result then
//   waits in the push step until the output register is free.
//   A new request is taken the cycle after its predecessor's result is loaded,
//   even if that result is still stalled at the output.
//   If the output register is still occupied when a result is ready, the
//   block holds the result until the receiver takes the older beat.
//   Reset clears the entry count, so the table is empty with no sweep; the
//   table RAM holds undefined data that is never read. heap_base resets to 0
//   and heap_limit to all ones. Configuration writes are registered.
// ----------------------------------------------------------------------------
module first_fit_block_allocator #(
    parameter int unsigned MAX_BLOCKS   = 64,
    parameter int unsigned HEADER_BYTES = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [ffba_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ffba_pkg::ADDR_W-1:0]           cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  mode,
    input  logic [ffba_pkg::ADDR_W-1:0]           request_size,
    input  logic [ffba_pkg::ADDR_W-1:0]           free_address,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [ffba_pkg::ADDR_W-1:0]           address,
    output logic [ffba_pkg::STATUS_W-1:0]         status
);

    localparam int unsigned AW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int unsigned CW  = $clog2(MAX_BLOCKS + 1);
    localparam int unsigned AWD = ffba_pkg::ADDR_W;
    localparam int unsigned SW  = ffba_pkg::STATUS_W;
    localparam logic [CW-1:0]    MAX_COUNT = CW'(MAX_BLOCKS);
    localparam logic [AWD:0]     HDR33     = (AWD+1)'(HEADER_BYTES);
    localparam logic [AWD+2:0]   HDR35     = (AWD+3)'(HEADER_BYTES);
    localparam logic [AWD-1:0]   HDR32     = AWD'(HEADER_BYTES);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_APPEND = 2'd2;
    localparam logic [1:0] S_PUSH   = 2'd3;

    logic [1:0]     state_reg, state_next;
    logic [AWD-1:0] heap_base_reg, heap_limit_reg;
    logic [CW-1:0]  count_reg, count_next;
    logic [AWD:0]   last_end_reg, last_end_next;
    logic [CW-1:0]  idx_reg, idx_next;
    logic           chk_valid_reg, chk_valid_next;
    logic [AW-1:0]  chk_idx_reg, chk_idx_next;
    logic           mode_reg, mode_next;
    logic [AWD:0]   size_reg, size_next;
    logic [AWD-1:0] faddr_reg, faddr_next;
    logic [AWD-1:0] res_addr_reg, res_addr_next;
    logic [SW-1:0]  res_status_reg, res_status_next;
    logic           out_valid_reg, out_valid_next;
    logic [AWD-1:0] address_reg, address_next;
    logic [SW-1:0]  status_reg, status_next;

    logic                  ram_wr_en, ram_rd_en;
    logic [AW-1:0]         ram_wr_addr;
    ffba_pkg::ffba_entry_t ram_wr_data, rd_entry;
    logic [ffba_pkg::ENTRY_W-1:0] ram_rd_data;

    logic           issue, hit, in_take, out_free;
    logic [AWD:0]   app_start;
    logic [AWD+2:0] app_end;

    ffba_ram #(
        .WIDTH (ffba_pkg::ENTRY_W),
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (ram_rd_data)
    );

    assign rd_entry  = ffba_pkg::ffba_entry_t'(ram_rd_data);
    assign in_stall  = (state_reg != S_IDLE);
    assign in_take   = in_valid && (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign address   = address_reg;
    assign status    = status_reg;

    assign issue     = (state_reg == S_SCAN) && (idx_reg < count_reg);
    assign ram_rd_en = issue;

    // entry under test is the one read last cycle
    always_comb
    begin
        hit = 1'b0;
        if (chk_valid_reg)
        begin
            if (mode_reg == ffba_pkg::MODE_ALLOC)
            begin
                hit = rd_entry.free && ({1'b0, rd_entry.size} >= size_reg);
            end
            else
            begin
                hit = (({1'b0, rd_entry.start} + HDR33) == {1'b0, faddr_reg});
            end
        end
    end

    // empty table starts at heap_base rounded up at 33 bits
    assign app_start = (count_reg == '0)
                     ? (({1'b0, heap_base_reg} + ffba_pkg::ALIGN_ADD) & ffba_pkg::ALIGN_MASK)
                     : last_end_reg;
    assign app_end   = {2'b00, app_start} + HDR35 + {2'b00, size_reg};

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        last_end_next   = last_end_reg;
        idx_next        = idx_reg;
        chk_valid_next  = 1'b0;
        chk_idx_next    = chk_idx_reg;
        mode_next       = mode_reg;
        size_next       = size_reg;
        faddr_next      = faddr_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && out_stall;
        address_next    = address_reg;
        status_next     = status_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = chk_idx_reg;
        ram_wr_data     = rd_entry;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    mode_next  = mode;
                    faddr_next = free_address;
                    size_next  = ({1'b0, request_size} + ffba_pkg::ALIGN_ADD)
                               & ffba_pkg::ALIGN_MASK;
                    idx_next   = '0;
                    if ((mode == ffba_pkg::MODE_ALLOC) && (request_size == '0))
                    begin
                        res_addr_next   = '0;
                        res_status_next = ffba_pkg::ST_ZERO_SIZE;
                        state_next      = S_PUSH;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    ram_wr_en = 1'b1;
                    if (mode_reg == ffba_pkg::MODE_ALLOC)
                    begin
                        ram_wr_data.free = 1'b0;
                        res_addr_next    = rd_entry.start + HDR32;
                        res_status_next  = ffba_pkg::ST_REUSED;
                    end
                    else
                    begin
                        ram_wr_data.free = 1'b1;
                        res_addr_next    = faddr_reg;
                        res_status_next  = ffba_pkg::ST_FREED;
                    end
                    state_next = S_PUSH;
                end
                else if (!issue && !chk_valid_reg)
                begin
                    if (mode_reg == ffba_pkg::MODE_ALLOC)
                    begin
                        state_next = S_APPEND;
                    end
                    else
                    begin
                        res_addr_next   = '0;
                        res_status_next = ffba_pkg::ST_UNKNOWN;
                        state_next      = S_PUSH;
                    end
                end
                else
                begin
                    chk_valid_next = issue;
                    chk_idx_next   = idx_reg[AW-1:0];
                    if (issue)
                    begin
                        idx_next = idx_reg + CW'(1);
                    end
                end
            end
            S_APPEND:
            begin
                if ((count_reg >= MAX_COUNT)
                    || ((app_end - (AWD+3)'(1)) > {3'b000, heap_limit_reg}))
                begin
                    res_addr_next   = '0;
                    res_status_next = ffba_pkg::ST_NO_SPACE;
                end
                else
                begin
                    ram_wr_en         = 1'b1;
                    ram_wr_addr       = count_reg[AW-1:0];
                    ram_wr_data.start = app_start[AWD-1:0];
                    ram_wr_data.size  = size_reg[AWD-1:0];
                    ram_wr_data.free  = 1'b0;
                    count_next        = count_reg + CW'(1);
                    last_end_next     = app_end[AWD:0];
                    res_addr_next     = app_start[AWD-1:0] + HDR32;
                    res_status_next   = ffba_pkg::ST_APPENDED;
                end
                state_next = S_PUSH;
            end
            S_PUSH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    address_next   = res_addr_reg;
                    status_next    = res_status_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            heap_base_reg  <= '0;
            heap_limit_reg <= '1;
            count_reg      <= '0;
            last_end_reg   <= '0;
            idx_reg        <= '0;
            chk_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            last_end_reg  <= last_end_next;
            idx_reg       <= idx_next;
            chk_valid_reg <= chk_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    ffba_pkg::CFG_HEAP_BASE:  heap_base_reg  <= cfg_data;
                    ffba_pkg::CFG_HEAP_LIMIT: heap_limit_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg    <= chk_idx_next;
        mode_reg       <= mode_next;
        size_reg       <= size_next;
        faddr_reg      <= faddr_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        address_reg    <= address_next;
        status_reg     <= status_next;
    end

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_COUNT)
        else $error("entry count beyond table depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> (count_reg == $past(count_reg) + CW'(1)))
        else $error("entry count moved by more than one");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ffba_pkg::ST_NO_SPACE || status == ffba_pkg::ST_ZERO_SIZE
                       || status == ffba_pkg::ST_UNKNOWN)) |-> (address == '0))
        else $error("failed request returned a nonzero address");

    a_result_from_push: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_PUSH))
        else $error("result beat loaded outside the push step");

endmodule
